[rtl/prtq_pkg.sv]
package prtq_pkg;

  // Fixed field widths
  localparam int PORT_W   = 6;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CAPL_W   = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ENQUEUE  = 2'd0;
  localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;
  localparam logic [OP_W-1:0] OP_VERIFY   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FRONT = 2'd2;

endpackage

[rtl/prtq_ring.sv]
module prtq_ring #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [prtq_pkg::PORT_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [prtq_pkg::PORT_W-1:0] rd_data
);
  import prtq_pkg::*;

  logic [PORT_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/port_request_turn_queue_top.sv]
// First-come turn queue of port numbers kept in a ring memory with one
// registered read port. One item is worked on at a time; busy is high while
// an item is in flight or a capacity write is presented. Enqueue and any item
// with a port number outside the port range finish in the idle state.
// Complete and verify do one ring read of the front entry, except on an empty
// queue. Clear walks the queued entries through the single read port, one
// entry per cycle, except on an empty queue. Each result appears on the
// result ports for one cycle with done high, registered as the work ends; the
// receiver cannot stall it, so results must be taken as they come. Writing
// capacity_log2 empties the queue.
module port_request_turn_queue_top #(
  parameter int MAX_DEPTH = 16,
  parameter int NUM_PORTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [prtq_pkg::OP_W-1:0]     opcode,
  input  logic [prtq_pkg::PORT_W-1:0]   port_number,
  // result channel
  output logic                          done,
  output logic [prtq_pkg::STATUS_W-1:0] status,
  output logic                          is_front,
  output logic                          removed,
  output logic [prtq_pkg::COUNT_W-1:0]  entry_count,
  output logic                          port_requested,
  // capacity register write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [prtq_pkg::CAPL_W-1:0]   cfg_data
);
  import prtq_pkg::*;

  localparam int PW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW  = $clog2(MAX_DEPTH + 1);
  localparam int FIW = $clog2(NUM_PORTS);
  localparam int EXW = 9;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FRONT = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  logic [1:0]           state;
  logic [PW-1:0]        wp;
  logic [PW-1:0]        rp;
  logic [CW-1:0]        count;
  logic [NUM_PORTS-1:0] flags;
  logic [CAPL_W-1:0]    cap_log2;
  logic [OP_W-1:0]      op_r;
  logic [PORT_W-1:0]    port_r;
  logic [PW-1:0]        cur;
  logic [PW-1:0]        prev;
  logic [CW-1:0]        idx;
  logic                 hit;

  // Ring memory controls
  logic              wr_en;
  logic [PW-1:0]     wr_addr;
  logic [PORT_W-1:0] wr_data;
  logic              rd_en;
  logic [PW-1:0]     rd_addr;
  logic [PORT_W-1:0] rd_data;

  // Capacity, saturated at the ring depth
  logic [EXW-1:0] cap_pow;
  logic [CW-1:0]  cap;

  assign cap_pow = EXW'(1) << cap_log2;
  assign cap     = (cap_pow > EXW'(MAX_DEPTH)) ? CW'(MAX_DEPTH) : cap_pow[CW-1:0];

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                            input logic [CW-1:0] c);
    logic [CW-1:0] n;
    n = CW'(p) + CW'(1);
    return (n >= c) ? '0 : n[PW-1:0];
  endfunction

  // Port under work: live input when idle, latched copy afterwards
  logic [PORT_W-1:0] act_port;
  logic [EXW-1:0]    port_ext;
  logic              in_range;
  logic [FIW-1:0]    fidx;
  logic              flag_now;

  assign act_port = (state == ST_IDLE) ? port_number : port_r;
  assign port_ext = EXW'(act_port);
  assign in_range = port_ext < EXW'(NUM_PORTS);
  assign fidx     = port_ext[FIW-1:0];
  assign flag_now = in_range & flags[fidx];

  // Handshakes
  logic accept;
  logic full;
  logic empty;

  assign busy      = (state != ST_IDLE) | cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = start & ~busy;
  assign full      = count >= cap;
  assign empty     = (count == '0);

  // Walk bookkeeping
  logic          walk_last;
  logic          hit_now;
  logic          front_match;
  logic [PW-1:0] cur_adv;

  assign walk_last   = (idx + CW'(1)) == count;
  assign hit_now     = hit | (rd_data == port_r);
  assign front_match = (rd_data == port_r);
  assign cur_adv     = advance(cur, cap);

  // Memory read and write requests
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rp;
    wr_en   = 1'b0;
    wr_addr = wp;
    wr_data = port_number;
    case (state)
      ST_IDLE: begin
        if (accept && in_range) begin
          if (opcode == OP_ENQUEUE) begin
            wr_en = ~full;
          end else begin
            rd_en = ~empty;
          end
        end
      end
      ST_WALK: begin
        // shift the entry one place toward the front once the port was found
        wr_en   = (idx != '0) & hit;
        wr_addr = prev;
        wr_data = rd_data;
        rd_en   = ~walk_last;
        rd_addr = cur_adv;
      end
      default: begin
      end
    endcase
  end

  prtq_ring #(
    .DEPTH (MAX_DEPTH),
    .AW    (PW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wp       <= '0;
      rp       <= '0;
      count    <= '0;
      flags    <= '0;
      cap_log2 <= CAPL_W'(4);
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            cap_log2 <= cfg_data;
            wp       <= '0;
            rp       <= '0;
            count    <= '0;
            flags    <= '0;
          end else if (start) begin
            if (!in_range) begin
              done <= 1'b1;
            end else begin
              case (opcode)
                OP_ENQUEUE: begin
                  done <= 1'b1;
                  if (!full) begin
                    flags[fidx] <= 1'b1;
                    wp          <= advance(wp, cap);
                    count       <= count + CW'(1);
                  end
                end
                OP_CLEAR: begin
                  if (empty) begin
                    done <= 1'b1;
                  end else begin
                    state <= ST_WALK;
                  end
                end
                default: begin
                  // complete and verify look at the front entry
                  if (empty) begin
                    done <= 1'b1;
                  end else begin
                    state <= ST_FRONT;
                  end
                end
              endcase
            end
          end
        end
        ST_FRONT: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (op_r == OP_COMPLETE && front_match) begin
            rp          <= advance(rp, cap);
            count       <= count - CW'(1);
            flags[fidx] <= 1'b0;
          end
        end
        ST_WALK: begin
          if (walk_last) begin
            done  <= 1'b1;
            state <= ST_IDLE;
            if (hit_now) begin
              wp          <= (wp == '0) ? PW'(cap - CW'(1)) : wp - PW'(1);
              count       <= count - CW'(1);
              flags[fidx] <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item latch and walk pointers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (accept) begin
        op_r   <= opcode;
        port_r <= port_number;
      end
      cur  <= rp;
      prev <= rp;
      idx  <= '0;
      hit  <= 1'b0;
    end else if (state == ST_WALK) begin
      cur  <= cur_adv;
      prev <= cur;
      idx  <= idx + CW'(1);
      hit  <= hit_now;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        status         <= STATUS_OK;
        is_front       <= 1'b0;
        removed        <= 1'b0;
        entry_count    <= COUNT_W'(count);
        port_requested <= flag_now;
        if (in_range) begin
          if (opcode == OP_ENQUEUE) begin
            if (full) begin
              status <= STATUS_FULL;
            end else begin
              entry_count    <= COUNT_W'(count + CW'(1));
              port_requested <= 1'b1;
            end
          end else if (opcode == OP_COMPLETE && empty) begin
            status <= STATUS_NOT_FRONT;
          end
        end
      end
      ST_FRONT: begin
        status         <= STATUS_OK;
        is_front       <= 1'b0;
        removed        <= 1'b0;
        entry_count    <= COUNT_W'(count);
        port_requested <= flag_now;
        if (op_r == OP_COMPLETE) begin
          if (front_match) begin
            entry_count    <= COUNT_W'(count - CW'(1));
            port_requested <= 1'b0;
          end else begin
            status <= STATUS_NOT_FRONT;
          end
        end else begin
          is_front <= front_match;
        end
      end
      ST_WALK: begin
        status         <= STATUS_OK;
        is_front       <= 1'b0;
        removed        <= hit_now;
        entry_count    <= hit_now ? COUNT_W'(count - CW'(1)) : COUNT_W'(count);
        port_requested <= hit_now ? 1'b0 : flag_now;
      end
      default: begin
        status <= STATUS_OK;
      end
    endcase
  end

endmodule
